// ===== hw/rtl/epoch_seconds_to_utc_date_macros.svh =====
// Assertion macros shared by the date converter RTL.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESUD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESUD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/esud_pkg.sv =====
// Types and constants for the seconds-to-calendar-date pipeline.
package esud_pkg;

    localparam int NUM_STAGES = 9;

    // Reciprocals: q = (x * RECIP) >> SHIFT is exact over the operand range used.
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // divide by 675, x < 2^25
    localparam int          DAY_SHIFT   = 35;
    localparam logic [17:0] HOUR_RECIP  = 18'd149131;    // divide by 3600, x < 2^17
    localparam int          HOUR_SHIFT  = 29;
    localparam logic [18:0] Q1460_RECIP = 19'd367720;    // divide by 1460, x < 2^18
    localparam int          Q1460_SHIFT = 29;
    localparam logic [18:0] Y365_RECIP  = 19'd367720;    // divide by 365, x < 2^18
    localparam int          Y365_SHIFT  = 27;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;      // divide by 60, x < 2^12
    localparam int          MIN_SHIFT   = 18;
    localparam logic [11:0] MP_RECIP    = 12'd3427;      // divide by 153, x < 2^11
    localparam int          MP_SHIFT    = 19;

    localparam logic [19:0] EPOCH_DAYS  = 20'd719468;    // 0000-03-01 to 1970-01-01
    localparam logic [19:0] ERA4_START  = 20'd584388;    // 4 * 146097
    localparam logic [19:0] ERA5_START  = 20'd730485;    // 5 * 146097
    localparam logic [17:0] ERA_LAST    = 18'd146096;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [31:0] secs;
        logic [50:0] pday;
        logic [15:0] days;
        logic [16:0] tod;
        logic [17:0] doe;
        logic        era_hi;
        logic [34:0] phour;
        logic [36:0] pa;
        logic [2:0]  cent;
        logic        last;
        logic [4:0]  hour;
        logic [11:0] rem;
        logic [17:0] num;
        logic [24:0] pmin;
        logic [36:0] pyoe;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } cvt_t;

    // First day of each March-based month within the year: (153 * mp + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_utc_date.sv =====
// Pipelined converter from 32-bit Unix seconds to a UTC calendar date and time.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_epoch_seconds (32 bits, unsigned)
//   m_        out        m_valid/m_ready    m_year, m_month, m_day_of_month,
//                                           m_hour, m_minute, m_second
//
// One transfer can enter in every clock cycle while s_ready is high; its result
// passes through the nine register stages of the datapath on its way to the output.
// Each stage holds at most one multiplication by a constant reciprocal or a
// short add and compare chain.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
// A stall on m_ready holds occupied stages with no gap after them; the rest move up,
// so nothing is lost or repeated and s_ready drops only when all stages are full.
`include "epoch_seconds_to_utc_date_macros.svh"

module epoch_seconds_to_utc_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);

    localparam int NS = esud_pkg::NUM_STAGES;

    esud_pkg::cvt_t stg_reg  [NS];
    esud_pkg::cvt_t stg_next [NS];
    logic [NS-1:0]  valid_reg;
    logic [NS:0]    ready;

    // Stage intermediate values.
    logic [25:0] s1_dmul;
    logic [25:0] s1_diff;
    logic [19:0] s2_z;
    logic [16:0] s3_hmul;
    logic [16:0] s3_rem;
    logic [7:0]  s4_a;
    logic [11:0] s5_mmul;
    logic [11:0] s5_sec;
    logic [8:0]  s6_yoe;
    logic [1:0]  s6_ycent;
    logic [17:0] s6_ydays;
    logic [17:0] s6_doy;
    logic [10:0] s7_t;
    logic [22:0] s7_p;
    logic [3:0]  s8_m;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        ready[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign s_ready = ready[0];

    always_comb begin
        // Stage 0: days = secs / 86400, done as (secs >> 7) / 675.
        stg_next[0]      = stg_reg[0];
        stg_next[0].secs = s_epoch_seconds;
        stg_next[0].pday = {26'd0, s_epoch_seconds[31:7]} * {25'd0, esud_pkg::DAY_RECIP};

        // Stage 1: quotient and remainder give the day count and the time of day.
        stg_next[1]      = stg_reg[0];
        stg_next[1].days = stg_reg[0].pday[esud_pkg::DAY_SHIFT +: 16];
        s1_dmul          = {10'd0, stg_next[1].days} * 26'd675;
        s1_diff          = {1'b0, stg_reg[0].secs[31:7]} - s1_dmul;
        stg_next[1].tod  = {s1_diff[9:0], stg_reg[0].secs[6:0]};

        // Stage 2: only eras four and five are reachable, so one compare picks it.
        stg_next[2]        = stg_reg[1];
        s2_z               = {4'd0, stg_reg[1].days} + esud_pkg::EPOCH_DAYS;
        stg_next[2].era_hi = (s2_z >= esud_pkg::ERA5_START);
        stg_next[2].doe    = stg_next[2].era_hi ? 18'(s2_z - esud_pkg::ERA5_START)
                                                : 18'(s2_z - esud_pkg::ERA4_START);
        stg_next[2].phour  = {18'd0, stg_reg[1].tod} * {17'd0, esud_pkg::HOUR_RECIP};

        // Stage 3: leap-day corrections inside the era, and the hour split.
        stg_next[3]      = stg_reg[2];
        stg_next[3].pa   = {19'd0, stg_reg[2].doe} * {18'd0, esud_pkg::Q1460_RECIP};
        if (stg_reg[2].doe >= 18'd146096) begin
            stg_next[3].cent = 3'd4;
        end else if (stg_reg[2].doe >= 18'd109572) begin
            stg_next[3].cent = 3'd3;
        end else if (stg_reg[2].doe >= 18'd73048) begin
            stg_next[3].cent = 3'd2;
        end else if (stg_reg[2].doe >= 18'd36524) begin
            stg_next[3].cent = 3'd1;
        end else begin
            stg_next[3].cent = 3'd0;
        end
        stg_next[3].last = (stg_reg[2].doe == esud_pkg::ERA_LAST);
        stg_next[3].hour = stg_reg[2].phour[esud_pkg::HOUR_SHIFT +: 5];
        s3_hmul          = {12'd0, stg_next[3].hour} * 17'd3600;
        s3_rem           = stg_reg[2].tod - s3_hmul;
        stg_next[3].rem  = s3_rem[11:0];

        // Stage 4: day count with the leap days taken out, and the minute product.
        stg_next[4]      = stg_reg[3];
        s4_a             = stg_reg[3].pa[esud_pkg::Q1460_SHIFT +: 8];
        stg_next[4].num  = stg_reg[3].doe - {10'd0, s4_a} + {15'd0, stg_reg[3].cent}
                           - {17'd0, stg_reg[3].last};
        stg_next[4].pmin = {13'd0, stg_reg[3].rem} * {12'd0, esud_pkg::MIN_RECIP};

        // Stage 5: year-of-era product, minute and second.
        stg_next[5]        = stg_reg[4];
        stg_next[5].pyoe   = {19'd0, stg_reg[4].num} * {18'd0, esud_pkg::Y365_RECIP};
        stg_next[5].minute = stg_reg[4].pmin[esud_pkg::MIN_SHIFT +: 6];
        s5_mmul            = {6'd0, stg_next[5].minute} * 12'd60;
        s5_sec             = stg_reg[4].rem - s5_mmul;
        stg_next[5].second = s5_sec[5:0];

        // Stage 6: year of era and day of the March-based year.
        stg_next[6]     = stg_reg[5];
        s6_yoe          = stg_reg[5].pyoe[esud_pkg::Y365_SHIFT +: 9];
        if (s6_yoe >= 9'd300) begin
            s6_ycent = 2'd3;
        end else if (s6_yoe >= 9'd200) begin
            s6_ycent = 2'd2;
        end else if (s6_yoe >= 9'd100) begin
            s6_ycent = 2'd1;
        end else begin
            s6_ycent = 2'd0;
        end
        s6_ydays        = {9'd0, s6_yoe} * 18'd365 + {11'd0, s6_yoe[8:2]}
                          - {16'd0, s6_ycent};
        s6_doy          = stg_reg[5].doe - s6_ydays;
        stg_next[6].yoe = s6_yoe;
        stg_next[6].doy = s6_doy[8:0];

        // Stage 7: month index counted from March, (5 * doy + 2) / 153.
        stg_next[7]    = stg_reg[6];
        s7_t           = {2'd0, stg_reg[6].doy} * 11'd5 + 11'd2;
        s7_p           = {12'd0, s7_t} * {11'd0, esud_pkg::MP_RECIP};
        stg_next[7].mp = s7_p[esud_pkg::MP_SHIFT +: 4];

        // Stage 8: calendar month, day and year; January and February
        // belong to the following civil year.
        stg_next[8]       = stg_reg[7];
        s8_m              = (stg_reg[7].mp < 4'd10) ? stg_reg[7].mp + 4'd3
                                                    : stg_reg[7].mp - 4'd9;
        stg_next[8].month = s8_m;
        stg_next[8].day   = 5'(stg_reg[7].doy - esud_pkg::month_start(stg_reg[7].mp) + 9'd1);
        stg_next[8].year  = {3'd0, stg_reg[7].yoe}
                            + (stg_reg[7].era_hi ? 12'd2000 : 12'd1600)
                            + {11'd0, (s8_m <= 4'd2)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign m_valid        = valid_reg[NS-1];
    assign m_year         = stg_reg[NS-1].year;
    assign m_month        = stg_reg[NS-1].month;
    assign m_day_of_month = stg_reg[NS-1].day;
    assign m_hour         = stg_reg[NS-1].hour;
    assign m_minute       = stg_reg[NS-1].minute;
    assign m_second       = stg_reg[NS-1].second;

    // Back-pressure reaches the input only when every stage is full and stalled.
    `ESUD_ASSERT_IMP(a_full_stall, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without a full pipeline")
    // An accepted transfer always lands in the first stage.
    `ESUD_ASSERT_NXT(a_enter, aclk, aresetn, s_valid && s_ready, valid_reg[0], "accepted transfer lost at entry")
    // Results stay inside the calendar.
    `ESUD_ASSERT_IMP(a_range, aclk, aresetn, m_valid, (m_month >= 4'd1) && (m_month <= 4'd12) && (m_day_of_month >= 5'd1) && (m_hour < 5'd24) && (m_minute < 6'd60) && (m_second < 6'd60), "time field out of range")
    `ESUD_ASSERT_IMP(a_year, aclk, aresetn, m_valid, (m_year >= 12'd1970) && (m_year <= 12'd2106), "year out of range")
    // February 29 appears only in Gregorian leap years.
    `ESUD_ASSERT_IMP(a_leap, aclk, aresetn, m_valid && (m_month == 4'd2) && (m_day_of_month == 5'd29), (m_year[1:0] == 2'd0) && (m_year != 12'd2100), "leap day in a common year")

endmodule

// ===== test/tb_epoch_seconds_to_utc_date.sv =====
// Testbench for the epoch-seconds to UTC calendar date converter, with its scoreboard.
module tb_epoch_seconds_to_utc_date;

    // Calendar arithmetic constants used by the date predictor.
    localparam int unsigned DAY_SECONDS       = 86400;
    localparam int unsigned HOUR_SECONDS      = 3600;
    localparam int unsigned MINUTE_SECONDS    = 60;
    localparam int unsigned YEAR_DAYS         = 365;
    localparam int unsigned ERA_DAYS          = 146097;
    localparam int unsigned ERA_YEARS         = 400;
    // Days from 0000-03-01 to 1970-01-01 in the proleptic Gregorian calendar.
    localparam int unsigned MARCH0_TO_EPOCH   = 719468;

    // Midnight at the start of February 28 in years around a leap-day decision:
    // 1972 and 2000 have a February 29, 2100 does not.
    localparam logic [31:0] FEB28_1972        = 32'd68083200;
    localparam logic [31:0] FEB28_2000        = 32'd951696000;
    localparam logic [31:0] FEB28_2100        = 32'd4107456000;

    localparam int RANDOM_ITEMS               = 750;
    localparam int LONG_HOLD_CYCLES           = 80;
    localparam int HOLD_START_ITEM            = 200;
    localparam int HOLD_BURST_ITEMS           = 40;
    localparam int DRAIN_ITEM                 = 450;
    localparam int SETTLE_CYCLES              = 2 * esud_pkg::NUM_STAGES + 4;
    localparam int CYCLE_LIMIT                = 200000;

    // One converted date and time, fields at the widths of the result ports.
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } utc_date_t;

    // A predicted date together with the timestamp it came from, for messages.
    typedef struct {
        logic [31:0] secs;
        utc_date_t   date;
    } pending_date_t;

    // Keeps the dates that accepted timestamps must produce, in order, and
    // compares every returned date against the oldest of them.
    class date_scoreboard;
        pending_date_t pending[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Exact days-to-civil conversion over 400-year eras, with the year
        // counted from March so that the leap day falls at its end.
        function utc_date_t predict_date(logic [31:0] secs);
            int unsigned days, day_secs, shifted, era, day_of_era, year_of_era;
            int unsigned day_of_year, march_month, mday, month, year, hour_secs;
            utc_date_t   r;
            days        = secs / DAY_SECONDS;
            day_secs    = secs % DAY_SECONDS;
            shifted     = days + MARCH0_TO_EPOCH;
            era         = shifted / ERA_DAYS;
            day_of_era  = shifted - era * ERA_DAYS;
            year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                           - day_of_era / (ERA_DAYS - 1)) / YEAR_DAYS;
            day_of_year = day_of_era - (YEAR_DAYS * year_of_era + year_of_era / 4
                                        - year_of_era / 100);
            march_month = (5 * day_of_year + 2) / 153;
            mday        = day_of_year - (153 * march_month + 2) / 5 + 1;
            month       = (march_month < 10) ? march_month + 3 : march_month - 9;
            year        = year_of_era + era * ERA_YEARS + ((month <= 2) ? 1 : 0);
            hour_secs   = day_secs % HOUR_SECONDS;
            r.year         = 12'(year);
            r.month        = 4'(month);
            r.day_of_month = 5'(mday);
            r.hour         = 5'(day_secs / HOUR_SECONDS);
            r.minute       = 6'(hour_secs / MINUTE_SECONDS);
            r.second       = 6'(hour_secs % MINUTE_SECONDS);
            return r;
        endfunction

        function void note_input(logic [31:0] secs);
            pending_date_t p;
            p.secs = secs;
            p.date = predict_date(secs);
            pending.push_back(p);
        endfunction

        function int pending_count();
            return pending.size();
        endfunction

        task report_mismatch(string what);
            $display("ERROR: %s", what);
            mismatches++;
        endtask

        task compare_field(string field, int unsigned got, int unsigned want,
                           logic [31:0] secs);
            if (got != want) begin
                report_mismatch($sformatf("%s for %0d seconds: got %0d, expected %0d",
                                          field, secs, got, want));
            end
        endtask

        task check_result(utc_date_t got);
            pending_date_t p;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("date %0d-%0d-%0d %0d:%0d:%0d with no input pending",
                                          got.year, got.month, got.day_of_month,
                                          got.hour, got.minute, got.second));
            end else begin
                p = pending.pop_front();
                compare_field("year", got.year, p.date.year, p.secs);
                compare_field("month", got.month, p.date.month, p.secs);
                compare_field("day_of_month", got.day_of_month, p.date.day_of_month, p.secs);
                compare_field("hour", got.hour, p.date.hour, p.secs);
                compare_field("minute", got.minute, p.date.minute, p.secs);
                compare_field("second", got.second, p.date.second, p.secs);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_epoch_seconds;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;

    date_scoreboard dates;

    // Traffic shaping shared between the source and the sink. When a side is
    // calm it never idles, which gives back-to-back stretches on that side.
    bit source_calm;
    bit sink_calm;
    // Counted up by the source to ask the sink for one long hold-off of m_ready;
    // the sink keeps its own count of the hold-offs it has served.
    int hold_requests;

    int cycle_count = 0;

    epoch_seconds_to_utc_date dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a correct run ends far below this many cycles, so reaching it
    // means the block hung or lost a transfer.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Monitor. It runs in the active region right after the rising edge, so it
    // sees the handshake signals and payloads as they were at that edge; all
    // updates made at the edge land later in the nonblocking region.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            dates.note_input(s_epoch_seconds);
        end
        if (aresetn && m_valid && m_ready) begin
            dates.check_result({m_year, m_month, m_day_of_month,
                                m_hour, m_minute, m_second});
        end
    end

    // Result sink. Before each transfer it stalls for a random number of cycles,
    // or for none while calm. A pending long hold-off request is added to the
    // stall, so m_ready stays low for a long stretch counted here, while the
    // source keeps pushing timestamps and the pipeline fills up behind it.
    initial begin : result_sink
        int unsigned stall;
        int          holds_served;
        holds_served = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 15);
            if (hold_requests > holds_served) begin
                holds_served = holds_served + 1;
                stall = stall + LONG_HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Offers one timestamp after a random gap and returns at the edge where
    // the transfer happens. Valid stays high across back-to-back transfers, so
    // each call makes at most one assignment to s_valid in any time step.
    task automatic send_seconds(input logic [31:0] secs);
        int unsigned gap;
        gap = source_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drops valid and waits until every accepted timestamp has its date back.
    // The first edge is always waited out so the monitor has counted the last
    // transfer before the count is read.
    task automatic wait_for_all_dates();
        s_valid <= 1'b0;
        do @(posedge aclk); while (dates.pending_count() != 0);
    endtask

    initial begin : stimulus
        int unsigned pick;
        logic [63:0] wide;
        logic [31:0] secs;
        logic [31:0] base;
        int          phase;

        dates           = new();
        source_calm     = 1'b0;
        sink_calm       = 1'b0;
        hold_requests   = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_epoch_seconds <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, every unit rollover of the time of
        // day, the leap day in a leap year and a century leap year, the missing
        // leap day of 2100, the signed 32-bit rollover and the last timestamp.
        send_seconds(32'd0);
        send_seconds(32'd1);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(32'd68169600);     // 1972-02-29 00:00:00
        send_seconds(32'd94694399);     // 1972-12-31 23:59:59
        send_seconds(32'd946684799);    // 1999-12-31 23:59:59
        send_seconds(32'd951782400);    // 2000-02-29 00:00:00
        send_seconds(32'd951868799);    // 2000-02-29 23:59:59
        send_seconds(32'd951868800);    // 2000-03-01 00:00:00
        send_seconds(32'd2147483647);
        send_seconds(32'd2147483648);
        send_seconds(32'd4107542399);   // 2100-02-28 23:59:59
        send_seconds(32'd4107542400);   // 2100-03-01 00:00:00
        send_seconds(32'hAAAA_AAAA);
        send_seconds(32'h5555_5555);
        send_seconds(32'hFFFF_FFFF);    // 2106-02-07 06:28:15

        // Random part. Every 64 items the traffic shape changes between both
        // sides idling, a calm source, a calm sink and both calm.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase       = (n / 64) % 4;
            source_calm = (phase == 1) || (phase == 3);
            sink_calm   = (phase >= 2);

            // Long sink hold-off against a source that sends back to back.
            if (n == HOLD_START_ITEM) begin
                hold_requests = hold_requests + 1;
            end
            if (n >= HOLD_START_ITEM && n < HOLD_START_ITEM + HOLD_BURST_ITEMS) begin
                source_calm = 1'b1;
            end

            // Let the pipeline run completely dry once in the middle.
            if (n == DRAIN_ITEM) begin
                wait_for_all_dates();
            end

            // Most timestamps are uniform over the whole 32-bit range, which
            // toggles every input bit. The rest sit at day boundaries or
            // around the end of February in leap and non-leap years.
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                secs = $urandom;
            end else if (pick < 8) begin
                wide = 64'($urandom_range(0, 49709)) * DAY_SECONDS;
                case ($urandom_range(0, 2))
                    0:       wide = wide;
                    1:       wide = wide + DAY_SECONDS - 1;
                    default: wide = wide + $urandom_range(0, DAY_SECONDS - 1);
                endcase
                secs = wide[31:0];
            end else begin
                case ($urandom_range(0, 2))
                    0:       base = FEB28_1972;
                    1:       base = FEB28_2000;
                    default: base = FEB28_2100;
                endcase
                secs = base + $urandom_range(0, 3 * DAY_SECONDS);
            end
            send_seconds(secs);
        end

        // Wait for the last dates, then a little longer so that a stray extra
        // transfer would still be caught by the monitor.
        wait_for_all_dates();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (dates.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== epoch_seconds_to_utc_date.f =====
+incdir+hw/rtl
hw/rtl/esud_pkg.sv
hw/rtl/epoch_seconds_to_utc_date.sv
test/tb_epoch_seconds_to_utc_date.sv
